// ----- rtl/svd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_pkg
// Shared constants for the 2x2 singular value thresholding pipeline.
// ----------------------------------------------------------------------------
package svd_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Two square roots run side by side: the rotation and reflection magnitudes.
	localparam int SQ_LANES  = 2;
	// Four scaled terms: e and h over 2p, f and g over 2r.
	localparam int NUM_LANES = 4;

endpackage

// ----- rtl/svd_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_isqrt
// Pipelined integer square root, one result bit per stage, two lanes, with
// a sideband word that travels along with each transaction.
// ----------------------------------------------------------------------------
module svd_isqrt
	import svd_pkg::*;
#(
	parameter int RW  = 34,
	parameter int SBW = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [SQ_LANES-1:0][2*RW-1:0]     rad,
	input  logic [SBW-1:0]                    sb_in,
	output logic                              out_valid,
	output logic [SQ_LANES-1:0][RW-1:0]       root,
	output logic [SBW-1:0]                    sb_out
);

	localparam int XW = 2 * RW;

	logic                           vld_s [1:RW];
	logic [SQ_LANES-1:0][XW-1:0]    rem_s [1:RW];
	logic [SQ_LANES-1:0][RW-1:0]    res_s [1:RW];
	logic [SBW-1:0]                 sb_s  [1:RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam int B = RW - 1 - k;

		logic                        cv;
		logic [SQ_LANES-1:0][XW-1:0] crem;
		logic [SQ_LANES-1:0][RW-1:0] cres;
		logic [SBW-1:0]              csb;
		logic [SQ_LANES-1:0][XW-1:0] nrem;
		logic [SQ_LANES-1:0][RW-1:0] nres;

		if (k == 0) begin : g_first
			assign cv   = in_valid;
			assign crem = rad;
			assign cres = '0;
			assign csb  = sb_in;
		end else begin : g_next
			assign cv   = vld_s[k];
			assign crem = rem_s[k];
			assign cres = res_s[k];
			assign csb  = sb_s[k];
		end

		// The remainder holds x - res^2; bit B is set when (2*res + 2^B) * 2^B fits.
		for (genvar l = 0; l < SQ_LANES; l++) begin : g_lane
			logic [XW-1:0] trial;
			logic          take;
			assign trial   = (XW'(cres[l]) << (B + 1)) | (XW'(1) << (2 * B));
			assign take    = (crem[l] >= trial);
			assign nrem[l] = take ? (crem[l] - trial) : crem[l];
			assign nres[l] = take ? (cres[l] | (RW'(1) << B)) : cres[l];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= nrem;
				res_s[k+1] <= nres;
				sb_s[k+1]  <= csb;
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign root      = res_s[RW];
	assign sb_out    = sb_s[RW];

endmodule

// ----- rtl/svd_rdiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_rdiv
// Pipelined restoring divider, four lanes, one quotient bit per stage, then
// round to nearest (ties away from zero) and apply the sign. A zero divisor
// gives zero.
// ----------------------------------------------------------------------------
module svd_rdiv
	import svd_pkg::*;
#(
	parameter int NW  = 68,
	parameter int DNW = 35,
	parameter int QW  = 33
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic [NUM_LANES-1:0][NW-1:0]     num,
	input  logic [NUM_LANES-1:0][DNW-1:0]    den,
	input  logic [NUM_LANES-1:0]             neg,
	output logic                             out_valid,
	output logic [NUM_LANES-1:0][QW:0]       quo
);

	localparam int RMW = (NW > DNW + QW) ? NW : DNW + QW;

	logic                             vld_s [1:QW];
	logic [NUM_LANES-1:0][RMW-1:0]    rem_s [1:QW];
	logic [NUM_LANES-1:0][QW-1:0]     q_s   [1:QW];
	logic [NUM_LANES-1:0][DNW-1:0]    den_s [1:QW];
	logic [NUM_LANES-1:0]             neg_s [1:QW];
	logic [NUM_LANES-1:0]             dz_s  [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int B = QW - 1 - k;

		logic                           cv;
		logic [NUM_LANES-1:0][RMW-1:0]  crem;
		logic [NUM_LANES-1:0][QW-1:0]   cq;
		logic [NUM_LANES-1:0][DNW-1:0]  cden;
		logic [NUM_LANES-1:0]           cneg;
		logic [NUM_LANES-1:0]           cdz;
		logic [NUM_LANES-1:0][RMW-1:0]  nrem;
		logic [NUM_LANES-1:0][QW-1:0]   nq;

		if (k == 0) begin : g_first
			assign cv   = in_valid;
			assign cq   = '0;
			assign cden = den;
			assign cneg = neg;
			for (genvar l = 0; l < NUM_LANES; l++) begin : g_init
				assign crem[l] = RMW'(num[l]);
				assign cdz[l]  = (den[l] == '0);
			end
		end else begin : g_next
			assign cv   = vld_s[k];
			assign crem = rem_s[k];
			assign cq   = q_s[k];
			assign cden = den_s[k];
			assign cneg = neg_s[k];
			assign cdz  = dz_s[k];
		end

		for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
			logic [RMW-1:0] trial;
			logic           take;
			assign trial   = RMW'(cden[l]) << B;
			assign take    = (crem[l] >= trial);
			assign nrem[l] = take ? (crem[l] - trial) : crem[l];
			assign nq[l]   = take ? (cq[l] | (QW'(1) << B)) : cq[l];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= nrem;
				q_s[k+1]   <= nq;
				den_s[k+1] <= cden;
				neg_s[k+1] <= cneg;
				dz_s[k+1]  <= cdz;
			end
		end
	end

	logic                         vld_rnd_q;
	logic [NUM_LANES-1:0][QW-1:0] q_rnd_q;
	logic [NUM_LANES-1:0]         neg_rnd_q;
	logic [NUM_LANES-1:0]         dz_rnd_q;
	logic                         vld_out_q;
	logic [NUM_LANES-1:0][QW:0]   quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_rnd_q <= 1'b0;
			vld_out_q <= 1'b0;
		end else if (en) begin
			vld_rnd_q <= vld_s[QW];
			vld_out_q <= vld_rnd_q;
		end
	end

	// Round up when twice the remainder reaches the divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				q_rnd_q[l] <= q_s[QW][l] +
					QW'(((RMW + 1)'(rem_s[QW][l]) << 1) >= (RMW + 1)'(den_s[QW][l]));
				quo_q[l]   <= dz_rnd_q[l] ? '0 :
					(neg_rnd_q[l] ? -(QW + 1)'(q_rnd_q[l]) : (QW + 1)'(q_rnd_q[l]));
			end
			neg_rnd_q <= neg_s[QW];
			dz_rnd_q  <= dz_s[QW];
		end
	end

	assign out_valid = vld_out_q;
	assign quo       = quo_q;

endmodule

// ----- rtl/svd_2x2_singular_value_threshold.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_2x2_singular_value_threshold
// Soft-thresholds the singular values of a 2x2 block C = A - U and rebuilds it.
// ----------------------------------------------------------------------------
// One 2x2 block enters per clock unless the pipe holds. The two bit-per-stage
// units in the pipe are the square root of the rotation and reflection
// magnitudes (DATA_WIDTH + 2 stages) and the rounding divider that rescales
// the four terms (DATA_WIDTH + 3 stages). The whole pipe holds while a result
// waits on m_tready, so input is taken in every cycle that the output side is
// free. The threshold register resets to 1.0 and must be written by the user
// only while the pipe is empty; the block does not enforce this.
// ----------------------------------------------------------------------------
module svd_2x2_singular_value_threshold
	import svd_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [DATA_WIDTH-2:0]                   cfg_data,  // shrink_threshold
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// az_00, az_01, az_10, az_11, u_00, u_01, u_10, u_11
	input  logic [8*DATA_WIDTH-1:0]                 s_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// x_00, x_01, x_10, x_11, zero fill
	output logic [((4*DATA_WIDTH+7)/8)*8-1:0]       m_tdata
);

	localparam int W   = DATA_WIDTH;
	localparam int OW  = ((4 * W + 7) / 8) * 8;
	localparam int CW  = W + 1;
	localparam int DW  = W + 2;
	localparam int MW  = W + 1;
	localparam int LO  = (MW + 1) / 2;
	localparam int HI  = MW - LO;
	localparam int RW  = W + 2;
	localparam int XW  = 2 * RW;
	localparam int SQW = RW + 1;
	localparam int DNW = RW + 1;
	localparam int SLO = (SQW + 1) / 2;
	localparam int SHI = SQW - SLO;
	localparam int NW  = MW + SQW;
	localparam int QW  = MW;
	localparam int TW  = QW + 1;
	localparam int SW  = TW + 1;

	localparam logic signed [SW-1:0] SMAX = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN = {{(SW - W + 1){1'b1}}, {(W - 1){1'b0}}};

	typedef struct packed {
		logic signed [DW-1:0] e;
		logic signed [DW-1:0] f;
		logic signed [DW-1:0] g;
		logic signed [DW-1:0] h;
	} quad_t;

	logic [W-2:0] shrink_threshold_q;
	logic         en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;

	logic signed [CW-1:0]            c_s1 [4];
	quad_t                           quad_s2, quad_s3, quad_s4, quad_s5, quad_s6;
	logic [MW-1:0]                   mag_s3 [4];
	logic [2*HI-1:0]                 hh_s4 [4];
	logic [HI+LO-1:0]                hl_s4 [4];
	logic [2*LO-1:0]                 ll_s4 [4];
	logic [XW-1:0]                   sqv_s5 [4];
	logic [SQ_LANES-1:0][XW-1:0]     rad_s6;

	logic                            sq_vld;
	logic [SQ_LANES-1:0][RW-1:0]     sq_root;
	logic [$bits(quad_t)-1:0]        sq_sb;
	quad_t                           quad_sq;

	logic [RW:0]                     sum_s7;
	logic [RW-1:0]                   dif_s7, p_s7, r_s7, p_s8, r_s8;
	logic                            pge_s7, pge_s8;
	quad_t                           quad_s7, quad_s8;
	logic [RW:0]                     h1_s8;
	logic [RW-1:0]                   m_s8;
	logic [W-1:0]                    t2;

	logic [SQW-1:0]                  sq_s9, sr_s9;
	logic [DNW-1:0]                  dp_s9, dr_s9, dp_s10, dr_s10;
	logic [MW-1:0]                   mag_s9 [4];
	logic [NUM_LANES-1:0]            neg_s9, neg_s10, neg_s11;
	logic [MW+SLO-1:0]               pl_s10 [4];
	logic [MW+SHI-1:0]               ph_s10 [4];
	logic [NUM_LANES-1:0][NW-1:0]    num_s11;
	logic [NUM_LANES-1:0][DNW-1:0]   den_s11;

	logic                            dv_vld;
	logic [NUM_LANES-1:0][TW-1:0]    dv_quo;
	logic signed [TW-1:0]            te, th, tf, tg;
	logic signed [SW-1:0]            sum_s12 [4];
	logic [3:0][W-1:0]               x_s13;

	assign en       = !v_s13 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s13;
	assign m_tdata  = OW'(x_s13);
	assign t2       = {shrink_threshold_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shrink_threshold_q <= (W - 1)'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			shrink_threshold_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s1  <= s_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= sq_vld;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= dv_vld;
			v_s13 <= v_s12;
		end
	end

	// Front end: difference, doubled sums, magnitudes and split squares.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				c_s1[i] <= CW'($signed(s_tdata[i*W +: W])) -
					CW'($signed(s_tdata[(4+i)*W +: W]));
			end

			quad_s2.e <= DW'(c_s1[0]) + DW'(c_s1[3]);
			quad_s2.f <= DW'(c_s1[0]) - DW'(c_s1[3]);
			quad_s2.g <= DW'(c_s1[2]) + DW'(c_s1[1]);
			quad_s2.h <= DW'(c_s1[2]) - DW'(c_s1[1]);

			quad_s3   <= quad_s2;
			mag_s3[0] <= quad_s2.e[DW-1] ? MW'(-quad_s2.e) : MW'(quad_s2.e);
			mag_s3[1] <= quad_s2.h[DW-1] ? MW'(-quad_s2.h) : MW'(quad_s2.h);
			mag_s3[2] <= quad_s2.f[DW-1] ? MW'(-quad_s2.f) : MW'(quad_s2.f);
			mag_s3[3] <= quad_s2.g[DW-1] ? MW'(-quad_s2.g) : MW'(quad_s2.g);

			quad_s4 <= quad_s3;
			for (int i = 0; i < 4; i++) begin
				hh_s4[i] <= mag_s3[i][MW-1:LO] * mag_s3[i][MW-1:LO];
				hl_s4[i] <= mag_s3[i][MW-1:LO] * mag_s3[i][LO-1:0];
				ll_s4[i] <= mag_s3[i][LO-1:0] * mag_s3[i][LO-1:0];
			end

			quad_s5 <= quad_s4;
			for (int i = 0; i < 4; i++) begin
				sqv_s5[i] <= (XW'(hh_s4[i]) << (2 * LO)) + (XW'(hl_s4[i]) << (LO + 1)) +
					XW'(ll_s4[i]);
			end

			quad_s6   <= quad_s5;
			rad_s6[0] <= sqv_s5[0] + sqv_s5[1];
			rad_s6[1] <= sqv_s5[2] + sqv_s5[3];
		end
	end

	svd_isqrt #(
		.RW  (RW),
		.SBW ($bits(quad_t))
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.rad       (rad_s6),
		.sb_in     (quad_s6),
		.out_valid (sq_vld),
		.root      (sq_root),
		.sb_out    (sq_sb)
	);

	assign quad_sq = quad_t'(sq_sb);

	// Thresholding of the doubled singular values p + r and |p - r|.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s7  <= (RW + 1)'(sq_root[0]) + (RW + 1)'(sq_root[1]);
			pge_s7  <= (sq_root[0] >= sq_root[1]);
			dif_s7  <= (sq_root[0] >= sq_root[1]) ? (sq_root[0] - sq_root[1]) :
				(sq_root[1] - sq_root[0]);
			p_s7    <= sq_root[0];
			r_s7    <= sq_root[1];
			quad_s7 <= quad_sq;

			h1_s8   <= (sum_s7 > (RW + 1)'(t2)) ? (sum_s7 - (RW + 1)'(t2)) : '0;
			m_s8    <= (dif_s7 > RW'(t2)) ? (dif_s7 - RW'(t2)) : '0;
			pge_s8  <= pge_s7;
			p_s8    <= p_s7;
			r_s8    <= r_s7;
			quad_s8 <= quad_s7;

			sq_s9  <= pge_s8 ? (h1_s8 + SQW'(m_s8)) : (h1_s8 - SQW'(m_s8));
			sr_s9  <= pge_s8 ? (h1_s8 - SQW'(m_s8)) : (h1_s8 + SQW'(m_s8));
			dp_s9  <= {p_s8, 1'b0};
			dr_s9  <= {r_s8, 1'b0};
			mag_s9[0] <= quad_s8.e[DW-1] ? MW'(-quad_s8.e) : MW'(quad_s8.e);
			mag_s9[1] <= quad_s8.h[DW-1] ? MW'(-quad_s8.h) : MW'(quad_s8.h);
			mag_s9[2] <= quad_s8.f[DW-1] ? MW'(-quad_s8.f) : MW'(quad_s8.f);
			mag_s9[3] <= quad_s8.g[DW-1] ? MW'(-quad_s8.g) : MW'(quad_s8.g);
			neg_s9 <= {quad_s8.g[DW-1], quad_s8.f[DW-1], quad_s8.h[DW-1], quad_s8.e[DW-1]};

			// Lanes e and h scale by sq, lanes f and g by sr; split in two halves.
			for (int i = 0; i < 4; i++) begin
				pl_s10[i] <= mag_s9[i] * ((i < 2) ? sq_s9[SLO-1:0] : sr_s9[SLO-1:0]);
				ph_s10[i] <= mag_s9[i] * ((i < 2) ? sq_s9[SQW-1:SLO] : sr_s9[SQW-1:SLO]);
			end
			neg_s10 <= neg_s9;
			dp_s10  <= dp_s9;
			dr_s10  <= dr_s9;

			for (int i = 0; i < 4; i++) begin
				num_s11[i] <= NW'(pl_s10[i]) + (NW'(ph_s10[i]) << SLO);
				den_s11[i] <= (i < 2) ? dp_s10 : dr_s10;
			end
			neg_s11 <= neg_s10;
		end
	end

	svd_rdiv #(
		.NW  (NW),
		.DNW (DNW),
		.QW  (QW)
	) u_rdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s11),
		.num       (num_s11),
		.den       (den_s11),
		.neg       (neg_s11),
		.out_valid (dv_vld),
		.quo       (dv_quo)
	);

	assign te = $signed(dv_quo[0]);
	assign th = $signed(dv_quo[1]);
	assign tf = $signed(dv_quo[2]);
	assign tg = $signed(dv_quo[3]);

	// Recombination, halving with ties away from zero, and saturation.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s12[0] <= SW'(te) + SW'(tf);
			sum_s12[1] <= SW'(tg) - SW'(th);
			sum_s12[2] <= SW'(th) + SW'(tg);
			sum_s12[3] <= SW'(te) - SW'(tf);

			for (int i = 0; i < 4; i++) begin
				logic signed [SW-1:0] hv;
				hv = sum_s12[i][SW-1] ? (sum_s12[i] >>> 1) : ((sum_s12[i] + SW'(1)) >>> 1);
				if (hv > SMAX) begin
					x_s13[i] <= SMAX[W-1:0];
				end else if (hv < SMIN) begin
					x_s13[i] <= SMIN[W-1:0];
				end else begin
					x_s13[i] <= hv[W-1:0];
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted transaction did not enter the first stage");

	a_sq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 |-> (sq_s9 <= dp_s9))
		else $error("shrunk rotation value exceeds its unshrunk magnitude");

	a_sr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 |-> (sr_s9 <= dr_s9))
		else $error("shrunk reflection value exceeds its unshrunk magnitude");
`endif

endmodule
